@@ rtl/mcch_pkg.sv @@
// ----------------------------------------------------------------------------
// mcch_pkg
// Shared types for the monotone chain convex hull block: controller states,
// the command group from controller to datapath and the status group back.
// ----------------------------------------------------------------------------
package mcch_pkg;

    localparam int RESULT_CAP = 64;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_SORT_I,
        ST_SORT_V,
        ST_SORT_J,
        ST_SORT_CMP,
        ST_SORT_PLACE,
        ST_HULL_INIT,
        ST_HULL_RD,
        ST_HULL_P,
        ST_HULL_TEST,
        ST_HULL_CMP,
        ST_HULL_POPW,
        ST_HULL_PUSH,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_EMIT_WAIT
    } state_t;

    typedef struct packed {
        logic load_pt;
        logic sort_init;
        logic sort_rd_i;
        logic sort_cap_v;
        logic sort_rd_prev;
        logic sort_shift;
        logic sort_place;
        logic hull_init;
        logic hull_step;
        logic hull_cap_p;
        logic hull_mul;
        logic hull_pop;
        logic hull_cap_t2;
        logic hull_push;
        logic emit_init;
        logic emit_rd;
        logic emit_load;
        logic emit_next;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic sort_done;
        logic j_zero;
        logic v_less;
        logic hull_done;
        logic hull_switch;
        logic pop_ok;
        logic not_ccw;
        logic emit_last;
    } status_t;

endpackage

@@ rtl/mcch_ctrl.sv @@
// ----------------------------------------------------------------------------
// mcch_ctrl
// Controller: sequences loading, insertion sort, hull construction and
// vertex output through commands to the datapath.
// ----------------------------------------------------------------------------
module mcch_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    input  logic             s_tlast,
    output logic             s_tready,
    output logic             m_tvalid,
    input  logic             m_tready,
    input  mcch_pkg::status_t sts,
    output mcch_pkg::cmd_t    cmd
);
    import mcch_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   in_xfer;
    logic   out_xfer;

    assign in_xfer  = s_tvalid && (state_reg == ST_LOAD);
    assign out_xfer = m_tready && (state_reg == ST_EMIT_WAIT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD: begin
                if (in_xfer && s_tlast) state_next = ST_SORT_I;
            end
            ST_SORT_I: begin
                state_next = sts.sort_done ? ST_HULL_INIT : ST_SORT_V;
            end
            ST_SORT_V: state_next = ST_SORT_J;
            ST_SORT_J: begin
                state_next = sts.j_zero ? ST_SORT_PLACE : ST_SORT_CMP;
            end
            ST_SORT_CMP: begin
                state_next = sts.v_less ? ST_SORT_J : ST_SORT_PLACE;
            end
            ST_SORT_PLACE: state_next = ST_SORT_I;
            ST_HULL_INIT: state_next = ST_HULL_RD;
            ST_HULL_RD: begin
                priority if (sts.hull_done) begin
                    state_next = ST_EMIT_RD;
                end else if (sts.hull_switch) begin
                    state_next = ST_HULL_RD;
                end else begin
                    state_next = ST_HULL_P;
                end
            end
            ST_HULL_P: state_next = ST_HULL_TEST;
            ST_HULL_TEST: begin
                state_next = sts.pop_ok ? ST_HULL_CMP : ST_HULL_PUSH;
            end
            ST_HULL_CMP: begin
                state_next = sts.not_ccw ? ST_HULL_POPW : ST_HULL_PUSH;
            end
            ST_HULL_POPW: state_next = ST_HULL_TEST;
            ST_HULL_PUSH: state_next = ST_HULL_RD;
            ST_EMIT_RD: state_next = ST_EMIT_LD;
            ST_EMIT_LD: state_next = ST_EMIT_WAIT;
            ST_EMIT_WAIT: begin
                if (out_xfer) state_next = sts.emit_last ? ST_LOAD : ST_EMIT_RD;
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        m_tvalid = 1'b0;
        unique case (state_reg)
            ST_LOAD: begin
                s_tready      = 1'b1;
                cmd.load_pt   = in_xfer;
                cmd.sort_init = in_xfer && s_tlast;
            end
            ST_SORT_I:     cmd.sort_rd_i = !sts.sort_done;
            ST_SORT_V:     cmd.sort_cap_v = 1'b1;
            ST_SORT_J:     cmd.sort_rd_prev = !sts.j_zero;
            ST_SORT_CMP:   cmd.sort_shift = sts.v_less;
            ST_SORT_PLACE: cmd.sort_place = 1'b1;
            ST_HULL_INIT:  cmd.hull_init = 1'b1;
            ST_HULL_RD: begin
                cmd.hull_step = !sts.hull_done;
                cmd.emit_init = sts.hull_done;
            end
            ST_HULL_P:     cmd.hull_cap_p = 1'b1;
            ST_HULL_TEST:  cmd.hull_mul = 1'b1;
            ST_HULL_CMP:   cmd.hull_pop = sts.not_ccw;
            ST_HULL_POPW:  cmd.hull_cap_t2 = 1'b1;
            ST_HULL_PUSH:  cmd.hull_push = 1'b1;
            ST_EMIT_RD:    cmd.emit_rd = 1'b1;
            ST_EMIT_LD:    cmd.emit_load = 1'b1;
            ST_EMIT_WAIT: begin
                m_tvalid      = 1'b1;
                cmd.emit_next = out_xfer;
                cmd.finish    = out_xfer && sts.emit_last;
            end
            default: cmd = '0;
        endcase
    end

endmodule

@@ rtl/mcch_datapath.sv @@
// ----------------------------------------------------------------------------
// mcch_datapath
// Datapath: point memory, hull stack memory, index counters, sort compare,
// cross product turn test and the output register.
// ----------------------------------------------------------------------------
module mcch_datapath #(
    parameter int MAX_POINTS = 32,
    parameter int COORD_BITS = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic [COORD_BITS-1:0]   pt_x,
    input  logic [COORD_BITS-1:0]   pt_y,
    input  mcch_pkg::cmd_t          cmd,
    output mcch_pkg::status_t       sts,
    output logic [COORD_BITS-1:0]   hull_x,
    output logic [COORD_BITS-1:0]   hull_y,
    output logic                    last_vertex,
    output logic                    overflow
);
    import mcch_pkg::*;

    localparam int PW      = 2 * COORD_BITS;
    localparam int CNT_W   = $clog2(MAX_POINTS + 1);
    localparam int IDX_W   = $clog2(MAX_POINTS);
    localparam int SDEPTH  = 2 * MAX_POINTS + 2;
    localparam int TOP_W   = $clog2(SDEPTH + 1);
    localparam int SADDR_W = $clog2(SDEPTH);
    localparam int DW      = COORD_BITS + 1;
    localparam int MW      = 2 * DW;

    logic [PW-1:0] pmem [MAX_POINTS];
    logic [PW-1:0] smem [SDEPTH];

    logic [PW-1:0]    pmem_q;
    logic [PW-1:0]    smem_q;
    logic [IDX_W-1:0] p_raddr;
    logic [IDX_W-1:0] p_waddr;
    logic [PW-1:0]    p_wdata;
    logic             p_we;
    logic [SADDR_W-1:0] s_raddr;

    logic [CNT_W-1:0] cnt_reg;
    logic             ovf_reg;
    logic [CNT_W-1:0] i_reg;
    logic [IDX_W-1:0] j_reg;
    logic [PW-1:0]    v_reg;
    logic             phase_reg;
    logic [TOP_W-1:0] top_reg;
    logic [TOP_W-1:0] floor_reg;
    logic [TOP_W-1:0] k_reg;
    logic [TOP_W-1:0] r_reg;
    logic [PW-1:0]    p_reg;
    logic [PW-1:0]    t1_reg;
    logic [PW-1:0]    t2_reg;
    logic signed [MW-1:0] m1_reg;
    logic signed [MW-1:0] m2_reg;
    logic [COORD_BITS-1:0] ox_reg;
    logic [COORD_BITS-1:0] oy_reg;
    logic             olast_reg;
    logic             oovf_reg;

    logic signed [COORD_BITS-1:0] vx;
    logic signed [COORD_BITS-1:0] vy;
    logic signed [COORD_BITS-1:0] qx;
    logic signed [COORD_BITS-1:0] qy;
    logic signed [DW-1:0] ax;
    logic signed [DW-1:0] ay;
    logic signed [DW-1:0] bx;
    logic signed [DW-1:0] by;
    logic [TOP_W-1:0] r_plus;

    assign vx = $signed(v_reg[COORD_BITS-1:0]);
    assign vy = $signed(v_reg[PW-1:COORD_BITS]);
    assign qx = $signed(pmem_q[COORD_BITS-1:0]);
    assign qy = $signed(pmem_q[PW-1:COORD_BITS]);

    assign ax = $signed({t1_reg[COORD_BITS-1], t1_reg[COORD_BITS-1:0]})
              - $signed({t2_reg[COORD_BITS-1], t2_reg[COORD_BITS-1:0]});
    assign ay = $signed({t1_reg[PW-1], t1_reg[PW-1:COORD_BITS]})
              - $signed({t2_reg[PW-1], t2_reg[PW-1:COORD_BITS]});
    assign bx = $signed({p_reg[COORD_BITS-1], p_reg[COORD_BITS-1:0]})
              - $signed({t2_reg[COORD_BITS-1], t2_reg[COORD_BITS-1:0]});
    assign by = $signed({p_reg[PW-1], p_reg[PW-1:COORD_BITS]})
              - $signed({t2_reg[PW-1], t2_reg[PW-1:COORD_BITS]});

    assign r_plus = r_reg + 1'b1;

    always_comb begin
        p_raddr = i_reg[IDX_W-1:0];
        priority if (cmd.sort_rd_prev) begin
            p_raddr = j_reg - 1'b1;
        end else if (cmd.hull_step && phase_reg) begin
            p_raddr = i_reg[IDX_W-1:0] - 1'b1;
        end else begin
            p_raddr = i_reg[IDX_W-1:0];
        end
    end

    always_comb begin
        p_we    = 1'b0;
        p_waddr = j_reg;
        p_wdata = v_reg;
        priority if (cmd.load_pt) begin
            p_we    = (cnt_reg < CNT_W'(MAX_POINTS));
            p_waddr = cnt_reg[IDX_W-1:0];
            p_wdata = {pt_y, pt_x};
        end else if (cmd.sort_shift) begin
            p_we    = 1'b1;
            p_wdata = pmem_q;
        end else if (cmd.sort_place) begin
            p_we    = 1'b1;
        end else begin
            p_we    = 1'b0;
        end
    end

    assign s_raddr = cmd.hull_pop ? SADDR_W'(top_reg - TOP_W'(3)) : r_reg[SADDR_W-1:0];

    always_ff @(posedge aclk) begin
        if (p_we) pmem[p_waddr] <= p_wdata;
        pmem_q <= pmem[p_raddr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.hull_push && (top_reg < TOP_W'(SDEPTH))) begin
            smem[top_reg[SADDR_W-1:0]] <= p_reg;
        end
        smem_q <= smem[s_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg   <= '0;
            ovf_reg   <= 1'b0;
            top_reg   <= '0;
            phase_reg <= 1'b0;
            i_reg     <= '0;
        end else begin
            if (cmd.load_pt) begin
                if (cnt_reg < CNT_W'(MAX_POINTS)) begin
                    cnt_reg <= cnt_reg + 1'b1;
                end else begin
                    ovf_reg <= 1'b1;
                end
            end
            if (cmd.sort_init) i_reg <= CNT_W'(1);
            if (cmd.sort_place) i_reg <= i_reg + 1'b1;
            if (cmd.hull_init) begin
                top_reg   <= '0;
                phase_reg <= 1'b0;
                i_reg     <= '0;
            end
            if (cmd.hull_step) begin
                priority if (sts.hull_switch) begin
                    phase_reg <= 1'b1;
                    i_reg     <= cnt_reg - 1'b1;
                end else if (phase_reg) begin
                    i_reg <= i_reg - 1'b1;
                end else begin
                    i_reg <= i_reg + 1'b1;
                end
            end
            if (cmd.hull_pop) top_reg <= top_reg - 1'b1;
            if (cmd.hull_push && (top_reg < TOP_W'(SDEPTH))) top_reg <= top_reg + 1'b1;
            if (cmd.finish) begin
                cnt_reg <= '0;
                ovf_reg <= 1'b0;
                top_reg <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.sort_rd_i) j_reg <= i_reg[IDX_W-1:0];
        if (cmd.sort_shift) j_reg <= j_reg - 1'b1;
        if (cmd.sort_cap_v) v_reg <= pmem_q;
        if (cmd.hull_step && sts.hull_switch) floor_reg <= top_reg + 1'b1;
        if (cmd.hull_init) floor_reg <= TOP_W'(2);
        if (cmd.hull_cap_p) p_reg <= pmem_q;
        if (cmd.hull_mul) begin
            m1_reg <= MW'(ax) * MW'(by);
            m2_reg <= MW'(ay) * MW'(bx);
        end
        if (cmd.hull_pop) t1_reg <= t2_reg;
        if (cmd.hull_cap_t2) t2_reg <= smem_q;
        if (cmd.hull_push) begin
            t2_reg <= t1_reg;
            t1_reg <= p_reg;
        end
        if (cmd.emit_init) begin
            k_reg <= (int'(top_reg) > RESULT_CAP) ? TOP_W'(RESULT_CAP) : top_reg;
            r_reg <= '0;
        end
        if (cmd.emit_next) r_reg <= r_plus;
        if (cmd.emit_load) begin
            ox_reg    <= smem_q[COORD_BITS-1:0];
            oy_reg    <= smem_q[PW-1:COORD_BITS];
            olast_reg <= (r_plus == k_reg);
            oovf_reg  <= ovf_reg;
        end
    end

    always_comb begin
        sts             = '0;
        sts.sort_done   = (i_reg >= cnt_reg);
        sts.j_zero      = (j_reg == '0);
        sts.v_less      = (vx < qx) || ((vx == qx) && (vy < qy));
        sts.hull_done   = phase_reg && (i_reg == '0);
        sts.hull_switch = !phase_reg && (i_reg == cnt_reg);
        sts.pop_ok      = (top_reg >= floor_reg) && (top_reg >= TOP_W'(2));
        sts.not_ccw     = (m1_reg <= m2_reg);
        sts.emit_last   = olast_reg;
    end

    assign hull_x      = ox_reg;
    assign hull_y      = oy_reg;
    assign last_vertex = olast_reg;
    assign overflow    = oovf_reg;

endmodule

@@ rtl/monotone_chain_convex_hull.sv @@
// ----------------------------------------------------------------------------
// monotone_chain_convex_hull
// Two-dimensional convex hull by the monotone chain method on signed points.
// ----------------------------------------------------------------------------
// Points enter on the slave stream, one per transfer, x in the low half of
// s_tdata and y above it; s_tlast marks the final point of a set. Up to
// MAX_POINTS points are kept; further points are dropped and the whole
// result set then carries m_tuser set.
// s_tready stays high while loading. After the final point the block sorts
// the set by insertion sort on a point memory with one read port and one
// write port, then builds the lower and upper hulls on a stack memory.
// Vertices leave counter-clockwise on the master stream, the first vertex
// repeated with m_tlast; each vertex is read from the stack memory and
// loaded into the output register before m_tvalid is raised.
// s_tready is low from the final point until the last vertex transfer.
// A stalled receiver holds the vertex in the output register. Reset returns
// the block to loading an empty set.
// ----------------------------------------------------------------------------
module monotone_chain_convex_hull #(
    parameter int MAX_POINTS = 32,
    parameter int COORD_BITS = 16
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    // point_x, point_y
    input  logic [((2*COORD_BITS+7)/8)*8-1:0] s_tdata,
    input  logic s_tlast,
    output logic m_tvalid,
    input  logic m_tready,
    // hull_x, hull_y
    output logic [((2*COORD_BITS+7)/8)*8-1:0] m_tdata,
    output logic m_tlast,
    // overflow
    output logic m_tuser
);
    import mcch_pkg::*;

    localparam int DATA_W = ((2*COORD_BITS+7)/8)*8;

    cmd_t    cmd;
    status_t sts;
    logic [COORD_BITS-1:0] hull_x;
    logic [COORD_BITS-1:0] hull_y;

    mcch_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    mcch_datapath #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .pt_x        (s_tdata[COORD_BITS-1:0]),
        .pt_y        (s_tdata[2*COORD_BITS-1:COORD_BITS]),
        .cmd         (cmd),
        .sts         (sts),
        .hull_x      (hull_x),
        .hull_y      (hull_y),
        .last_vertex (m_tlast),
        .overflow    (m_tuser)
    );

    assign m_tdata = DATA_W'({hull_y, hull_x});

endmodule

@@ rtl/mcch_checker.sv @@
// ----------------------------------------------------------------------------
// mcch_checker
// Port-level checks for the convex hull block, bound to the top level.
// ----------------------------------------------------------------------------
module mcch_checker #(
    parameter int DATA_W = 32
) (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_tready,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [DATA_W-1:0] m_tdata,
    input logic              m_tlast
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input accepted while a result is offered");

    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_tvalid && s_tready)
        else $error("block not idle after reset");

    a_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast |=> s_tready)
        else $error("block did not return to loading after final vertex");

endmodule

bind monotone_chain_convex_hull mcch_checker #(
    .DATA_W (((2*COORD_BITS+7)/8)*8)
) u_mcch_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
